// ===== hdl/rational_arith_unit_macros.svh =====
// Assertion macros shared by the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH
// Assert that a property holds at every rising clock edge outside reset.
`define RAU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Assert that a condition implies a consequent in the next cycle.
`define RAU_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) else $error(msg);
`endif

// ===== hdl/rau_pkg.sv =====
//------------------------------------------------------------------------------
// rau_pkg
// Shared constants and types of the rational arithmetic unit.
//------------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
	localparam int W = 32;
	localparam int MW = 2 * W;
	localparam logic [MW-1:0] LIMIT = MW'(1) << (W - 1);

	typedef enum logic [2:0] {
		ACT_NORM = 3'd0,
		ACT_ADD  = 3'd1,
		ACT_SUB  = 3'd2,
		ACT_MUL  = 3'd3,
		ACT_DIV  = 3'd4,
		ACT_CMP  = 3'd5,
		ACT_SPLIT = 3'd6,
		ACT_NONE = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	// Sequencer states of the top level.
	typedef enum logic [3:0] {
		S_IDLE, S_LOADB, S_GCD_GO, S_GCD_WT, S_DN_GO, S_DN_WT, S_DD_GO, S_DD_WT,
		S_MUL1, S_MUL2, S_COMB, S_SPL_GO, S_SPL_WT, S_FIN, S_OUT
	} state_t;

	// Command and status between the sequencer and the divider.
	typedef struct packed {
		logic          start;
		logic [MW-1:0] dividend;
		logic [MW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic          busy;
		logic          done;
		logic [MW-1:0] quot;
		logic [MW-1:0] rem;
	} div_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/rau_divider.sv =====
//------------------------------------------------------------------------------
// rau_divider
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit operands.
//------------------------------------------------------------------------------
`default_nettype none
`include "rational_arith_unit_macros.svh"
module rau_divider import rau_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic [MW-1:0] quot_q, rem_q, dvs_q;
	logic [6:0] cnt_q;
	logic busy_q, done_q;
	logic [MW:0] trial;
	logic [MW:0] shifted;

	assign shifted = {rem_q, quot_q[MW-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(MW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quot_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[MW]) begin
				rem_q <= trial[MW-1:0];
				quot_q <= {quot_q[MW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[MW-1:0];
				quot_q <= {quot_q[MW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem = rem_q;

	`RAU_ASSERT(a_div_done_one, !(busy_q && done_q), "divider done while busy")
	`RAU_ASSERT_NEXT(a_div_start, req.start && !busy_q, busy_q, "divider failed to start")
	`RAU_ASSERT(a_div_cnt, !busy_q || (cnt_q != 7'd0 && cnt_q <= 7'(MW)), "divider count out of range")
endmodule
`default_nettype wire

// ===== hdl/rational_arith_unit.sv =====
//------------------------------------------------------------------------------
// rational_arith_unit
// Exact arithmetic on two fractions with reduction by the greatest common
// divisor, sequenced over one shared 64-bit divider and one multiplier.
//------------------------------------------------------------------------------
// Channel  Dir  Beat contents
// s_axis   in   tdata: a_num, a_den, b_num, b_den (128b); tuser: action
// m_axis   out  tdata: res_num, res_den, int_part, flags, status (104b)
//
// Every item passes through the shared radix-2 divider: each Euclid step and
// each exact division is one divider pass (a start, one shift per quotient bit
// and a done). Both operand reductions need at least four passes; the longest
// Euclid chains on full-width operands and on the 64-bit result need about 186.
// The block takes no new beat until the result beat has been taken. Reset is
// asynchronous and clears the sequencer and the output valid. A stalled output
// simply holds the result register.
//------------------------------------------------------------------------------
`default_nettype none
`include "rational_arith_unit_macros.svh"
module rational_arith_unit import rau_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [31:0] a_num, [63:32] a_den, [95:64] b_num, [127:96] b_den
	input  wire logic [127:0] s_axis_tdata,
	// [2:0] action
	input  wire logic [2:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [31:0] res_num, [62:32] res_den, [94:63] int_part, [95] is_less,
	// [96] is_equal, [97] is_greater, [99:98] status, [103:100] zero
	output logic [103:0]      m_axis_tdata
);
	// The reduction routine (GCD then two divisions) is shared by operand a,
	// operand b and the result; ret_q says who called.
	typedef enum logic [1:0] { R_A, R_B, R_RES } ret_t;

	state_t state_q, state_d;
	ret_t ret_q;
	action_t act_q;
	logic [W-1:0] bnr_q, bdr_q;
	logic an_q, bn_q, rn_q;
	logic [MW-1:0] am_q, ad_q, bm_q, bd_q, rm_q, rd_q, ip_q;
	logic [MW-1:0] gx_q, gy_q, gg_q;
	logic [MW-1:0] p1_q, p2_q;
	logic a_ok_q, b_ok_q;
	div_req_t dreq;
	div_rsp_t drsp;
	logic ovld_q;
	logic [1:0] st_r_q;
	logic [2:0] flags_q;
	logic [W-1:0] ipf_q, rnf_q;
	logic [W-2:0] rdf_q;

	rau_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	function automatic logic [MW-1:0] mag(input logic [W-1:0] v);
		logic [W-1:0] neg_v;
		neg_v = ~v + W'(1);
		return v[W-1] ? {{(MW-W){1'b0}}, neg_v} : {{(MW-W){1'b0}}, v};
	endfunction

	// 32x32 multiplier: reduced operand magnitudes never exceed 2^31.
	logic [W-1:0] mul_x, mul_y;
	logic [MW-1:0] mul_p;
	assign mul_p = mul_x * mul_y;

	always_comb begin
		mul_x = am_q[W-1:0];
		mul_y = bd_q[W-1:0];
		if (state_q == S_MUL2) begin
			mul_x = bm_q[W-1:0];
			mul_y = ad_q[W-1:0];
		end
		if (act_q == ACT_MUL) begin
			mul_x = (state_q == S_MUL1) ? am_q[W-1:0] : ad_q[W-1:0];
			mul_y = (state_q == S_MUL1) ? bm_q[W-1:0] : bd_q[W-1:0];
		end
		if (act_q == ACT_DIV) begin
			mul_x = (state_q == S_MUL1) ? am_q[W-1:0] : ad_q[W-1:0];
			mul_y = (state_q == S_MUL1) ? bd_q[W-1:0] : bm_q[W-1:0];
		end
		// The add/sub denominator ad*bd is formed while the sum is combined.
		if (state_q == S_COMB) begin
			mul_x = ad_q[W-1:0];
			mul_y = bd_q[W-1:0];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (s_axis_tvalid) state_d = S_GCD_GO;
			S_LOADB:  state_d = S_GCD_GO;
			S_GCD_GO: state_d = (gy_q == '0) ? S_DN_GO : S_GCD_WT;
			S_GCD_WT: if (drsp.done) state_d = S_GCD_GO;
			S_DN_GO:  state_d = S_DN_WT;
			S_DN_WT:  if (drsp.done) state_d = S_DD_GO;
			S_DD_GO:  state_d = S_DD_WT;
			S_DD_WT:  if (drsp.done) begin
				if (ret_q == R_A) state_d = S_LOADB;
				else if (ret_q == R_B) state_d = S_MUL1;
				else state_d = S_FIN;
			end
			S_MUL1:   state_d = S_MUL2;
			S_MUL2:   state_d = S_COMB;
			S_COMB:   begin
				if (!a_ok_q || act_q == ACT_NONE) state_d = S_FIN;
				else if (act_q == ACT_NORM) state_d = S_FIN;
				else if (act_q == ACT_SPLIT) state_d = S_SPL_GO;
				else if (!b_ok_q || act_q == ACT_CMP) state_d = S_FIN;
				else if (act_q == ACT_DIV && bm_q == '0) state_d = S_FIN;
				else state_d = S_GCD_GO;
			end
			S_SPL_GO: state_d = S_SPL_WT;
			S_SPL_WT: if (drsp.done) state_d = S_FIN;
			S_FIN:    state_d = S_OUT;
			S_OUT:    if (m_axis_tready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Divider commands.
	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = gx_q;
		dreq.divisor = gy_q;
		unique case (state_q)
			S_GCD_GO: dreq.start = (gy_q != '0);
			S_DN_GO:  begin
				dreq.start = 1'b1;
				dreq.dividend = gg_q == '0 ? '0 : rm_q;
				dreq.divisor = gx_q == '0 ? MW'(1) : gx_q;
			end
			S_DD_GO:  begin
				dreq.start = 1'b1;
				dreq.dividend = rd_q;
				dreq.divisor = gg_q;
			end
			S_SPL_GO: begin
				dreq.start = 1'b1;
				dreq.dividend = am_q;
				dreq.divisor = ad_q;
			end
			default:  dreq.start = 1'b0;
		endcase
	end

	// Datapath registers.
	logic [MW:0] sum;
	logic fa_neg, fb_neg;
	logic [1:0] st;
	logic lt, eq, gt;
	always_comb begin
		fb_neg = (act_q == ACT_SUB) ? !bn_q : bn_q;
		fa_neg = an_q;
		sum = '0;
		if (fa_neg == fb_neg) sum = {1'b0, p1_q} + {1'b0, p2_q};
		else if (p1_q >= p2_q) sum = {1'b0, p1_q - p2_q};
		else sum = {1'b0, p2_q - p1_q};
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				act_q <= action_t'(s_axis_tuser);
				bnr_q <= s_axis_tdata[95:64];
				bdr_q <= s_axis_tdata[127:96];
				ret_q <= R_A;
				// Operand a goes first through the reduction.
				rn_q <= s_axis_tdata[31] != s_axis_tdata[63];
				rm_q <= mag(s_axis_tdata[31:0]);
				rd_q <= mag(s_axis_tdata[63:32]);
				gx_q <= mag(s_axis_tdata[31:0]);
				gy_q <= mag(s_axis_tdata[63:32]);
				a_ok_q <= s_axis_tdata[63:32] != '0;
			end
			S_LOADB: begin
				if (ret_q == R_A) begin
					an_q <= (rm_q != '0) && rn_q;
					am_q <= rm_q;
					ad_q <= rd_q;
				end
				ret_q <= R_B;
				rn_q <= bnr_q[W-1] != bdr_q[W-1];
				rm_q <= mag(bnr_q);
				rd_q <= mag(bdr_q);
				gx_q <= mag(bnr_q);
				gy_q <= mag(bdr_q);
				b_ok_q <= bdr_q != '0;
			end
			S_GCD_GO: begin
				if (gy_q == '0) gg_q <= (gx_q == '0) ? MW'(1) : gx_q;
			end
			S_GCD_WT: if (drsp.done) begin
				gx_q <= gy_q;
				gy_q <= drsp.rem;
			end
			S_DN_GO: begin
				gx_q <= gg_q;
				gg_q <= gg_q;
			end
			S_DN_WT: if (drsp.done) rm_q <= drsp.quot;
			S_DD_WT: if (drsp.done) begin
				rd_q <= drsp.quot;
				if (rm_q == '0) rn_q <= 1'b0;
				if (ret_q == R_B) begin
					bn_q <= (rm_q != '0) && rn_q;
					bm_q <= rm_q;
					bd_q <= drsp.quot;
				end
			end
			S_MUL1: p1_q <= mul_p;
			S_MUL2: p2_q <= mul_p;
			S_COMB: begin
				ret_q <= R_RES;
				ip_q <= '0;
				unique case (act_q)
					ACT_NORM: begin
						rn_q <= an_q;
						rm_q <= am_q;
						rd_q <= ad_q;
					end
					ACT_ADD, ACT_SUB: begin
						rn_q <= (fa_neg == fb_neg || p1_q >= p2_q) ? fa_neg : fb_neg;
						rm_q <= sum[MW-1:0];
						rd_q <= mul_p;
						gx_q <= sum[MW-1:0];
						gy_q <= mul_p;
					end
					default: begin
						rn_q <= an_q != bn_q;
						rm_q <= p1_q;
						rd_q <= p2_q;
						gx_q <= p1_q;
						gy_q <= p2_q;
					end
				endcase
			end
			S_SPL_WT: if (drsp.done) begin
				ip_q <= drsp.quot;
				rm_q <= drsp.rem;
				rd_q <= ad_q;
				rn_q <= an_q && drsp.rem != '0;
			end
			default: begin
			end
		endcase
	end

	// Result formatting and error/overflow checks, evaluated in S_FIN.
	logic [W-1:0] rnum_f, ip_f, rden_f;
	logic [MW-1:0] ipm;
	always_comb begin
		st = ST_OK;
		lt = 1'b0; eq = 1'b0; gt = 1'b0;
		ipm = (act_q == ACT_SPLIT) ? ip_q : '0;
		if (act_q == ACT_NONE) st = ST_OK;
		else if (!a_ok_q) st = ST_ZERO;
		else if (act_q != ACT_NORM && act_q != ACT_SPLIT && !b_ok_q) st = ST_ZERO;
		else if (act_q == ACT_DIV && bm_q == '0) st = ST_ZERO;
		else if (act_q != ACT_CMP) begin
			if ((rn_q ? rm_q > LIMIT : rm_q >= LIMIT) || rd_q >= LIMIT ||
			    (an_q && ipm != '0 ? ipm > LIMIT : ipm >= LIMIT))
				st = ST_OVF;
		end
		if (st == ST_OK && act_q == ACT_CMP) begin
			if (an_q && am_q != '0 && !(bn_q && bm_q != '0)) lt = 1'b1;
			else if (!(an_q && am_q != '0) && bn_q && bm_q != '0) gt = 1'b1;
			else if (p1_q == p2_q) eq = 1'b1;
			else if (!(an_q && am_q != '0)) begin lt = p1_q < p2_q; gt = p1_q > p2_q; end
			else begin lt = p1_q > p2_q; gt = p1_q < p2_q; end
		end
		rnum_f = (st != ST_OK || act_q == ACT_NONE || act_q == ACT_CMP) ? '0 :
			(rn_q ? W'(0) - rm_q[W-1:0] : rm_q[W-1:0]);
		rden_f = (st != ST_OK || act_q == ACT_NONE || act_q == ACT_CMP) ? W'(1) :
			rd_q[W-1:0];
		ip_f = (st != ST_OK || act_q != ACT_SPLIT) ? '0 :
			((an_q && ipm != '0) ? W'(0) - ipm[W-1:0] : ipm[W-1:0]);
	end

	// Output register and handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN) ovld_q <= 1'b1;
			else if (m_axis_tready) ovld_q <= 1'b0;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata = {4'd0, st_r_q, flags_q, ipf_q, rdf_q, rnf_q};

	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			st_r_q <= st;
			flags_q <= {gt, eq, lt};
			ipf_q <= ip_f;
			rnf_q <= rnum_f;
			rdf_q <= rden_f[W-2:0];
		end
	end

	`RAU_ASSERT(a_rdy_idle, !(s_axis_tready && m_axis_tvalid), "accepting while result pending")
	`RAU_ASSERT(a_den_pos, !m_axis_tvalid || m_axis_tdata[62:32] != '0, "zero denominator out")
	`RAU_ASSERT(a_flags, !m_axis_tvalid || $countones(m_axis_tdata[97:95]) <= 1, "flags not exclusive")
	`RAU_ASSERT_NEXT(a_fin, state_q == S_FIN, m_axis_tvalid, "result not presented")
endmodule
`default_nettype wire

// ===== verif/rational_arith_unit_tb.sv =====
//------------------------------------------------------------------------------
// rational_arith_unit_tb
// Drives fraction pairs with every action into the rational arithmetic unit
// and checks each result beat against a predictor of the exact arithmetic.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module rational_arith_unit_tb import rau_pkg::*; ();

	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam logic [63:0] HALF_RANGE = 64'h8000_0000;

	typedef struct {
		bit          neg;
		logic [63:0] num;
		logic [63:0] den;
	} frac_t;

	typedef struct {
		logic [31:0] num;
		logic [30:0] den;
		logic [31:0] ipart;
		logic        lt;
		logic        eq;
		logic        gt;
		logic [1:0]  st;
	} quotient_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [2:0]   s_axis_tuser = ACT_NORM;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;

	quotient_t expected_q[$];
	int        fail_count = 0;
	longint    cycle_count = 0;
	int        rx_hold = 0;
	int        rx_stall = 0;

	rational_arith_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	//--------------------------------------------------------------------------
	// Predictor of the exact fraction arithmetic.
	//--------------------------------------------------------------------------
	function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return (x != 0) ? x : 64'd1;
	endfunction

	function automatic frac_t reduce_frac(frac_t f);
		logic [63:0] g;
		g = euclid_gcd(f.num, f.den);
		f.num = f.num / g;
		f.den = f.den / g;
		if (f.num == 0)
			f.neg = 1'b0;
		return f;
	endfunction

	// Magnitude of a 32-bit two's complement word, widened to 64 bits.
	function automatic logic [63:0] word_mag(logic [31:0] w);
		logic [31:0] t;
		t = w[31] ? -w : w;
		return {32'b0, t};
	endfunction

	// Returns 0 when the denominator is zero.
	function automatic bit load_frac(logic [31:0] n, logic [31:0] d, output frac_t f);
		f.num = word_mag(n);
		f.den = word_mag(d);
		f.neg = n[31] != d[31];
		if (f.den == 0)
			return 1'b0;
		f = reduce_frac(f);
		return 1'b1;
	endfunction

	function automatic bit fits_word(bit neg, logic [63:0] m);
		return neg ? (m <= HALF_RANGE) : (m < HALF_RANGE);
	endfunction

	function automatic quotient_t predict_quotient(action_t act, logic [31:0] an,
		logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
		frac_t       a, b, r;
		bit          a_ok, b_ok, bneg, ip_neg;
		logic [63:0] m1, m2, ip_mag;
		int          order;
		status_t     st;
		quotient_t   q;
		a_ok = load_frac(an, ad, a);
		b_ok = load_frac(bn, bd, b);
		r = '{1'b0, 64'd0, 64'd1};
		ip_neg = 1'b0;
		ip_mag = 0;
		order = 0;
		st = ST_OK;
		if (act == ACT_NONE) begin
		end else if (!a_ok || (act inside {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_CMP}
				&& !b_ok)) begin
			st = ST_ZERO;
		end else begin
			case (act)
				ACT_NORM: r = a;
				ACT_ADD, ACT_SUB: begin
					bneg = (act == ACT_SUB) ? !b.neg : b.neg;
					m1 = a.num * b.den;
					m2 = b.num * a.den;
					if (a.neg == bneg) begin
						r.neg = a.neg;
						r.num = m1 + m2;
					end else if (m1 >= m2) begin
						r.neg = a.neg;
						r.num = m1 - m2;
					end else begin
						r.neg = bneg;
						r.num = m2 - m1;
					end
					r.den = a.den * b.den;
					r = reduce_frac(r);
				end
				ACT_MUL: begin
					r.neg = a.neg != b.neg;
					r.num = a.num * b.num;
					r.den = a.den * b.den;
					r = reduce_frac(r);
				end
				ACT_DIV: begin
					if (b.num == 0) begin
						st = ST_ZERO;
					end else begin
						r.neg = a.neg != b.neg;
						r.num = a.num * b.den;
						r.den = a.den * b.num;
						r = reduce_frac(r);
					end
				end
				ACT_CMP: begin
					// Reduced operands never carry a negative zero.
					m1 = a.num * b.den;
					m2 = b.num * a.den;
					if (a.neg != b.neg)
						order = a.neg ? -1 : 1;
					else if (m1 == m2)
						order = 0;
					else if (!a.neg)
						order = (m1 < m2) ? -1 : 1;
					else
						order = (m1 > m2) ? -1 : 1;
				end
				default: begin
					ip_neg = a.neg;
					ip_mag = a.num / a.den;
					r.num = a.num % a.den;
					r.den = a.den;
					r.neg = a.neg && r.num != 0;
					if (ip_mag == 0)
						ip_neg = 1'b0;
				end
			endcase
		end
		if (st == ST_OK && act != ACT_CMP && act != ACT_NONE) begin
			if (!fits_word(r.neg, r.num) || r.den >= HALF_RANGE || !fits_word(ip_neg, ip_mag))
				st = ST_OVF;
		end
		if (st != ST_OK) begin
			r = '{1'b0, 64'd0, 64'd1};
			ip_neg = 1'b0;
			ip_mag = 0;
			order = 0;
		end
		q.num = r.neg ? -r.num[31:0] : r.num[31:0];
		q.den = r.den[30:0];
		q.ipart = ip_neg ? -ip_mag[31:0] : ip_mag[31:0];
		q.lt = st == ST_OK && act == ACT_CMP && order < 0;
		q.eq = st == ST_OK && act == ACT_CMP && order == 0;
		q.gt = st == ST_OK && act == ACT_CMP && order > 0;
		q.st = st;
		return q;
	endfunction

	//--------------------------------------------------------------------------
	// Input side.
	//--------------------------------------------------------------------------
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	// Valid stays high from one beat to the next when no gap is drawn.
	task automatic send_fractions(action_t act, logic [31:0] an, logic [31:0] ad,
		logic [31:0] bn, logic [31:0] bd, int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {bd, bn, ad, an};
		s_axis_tuser <= act;
		do @(posedge clk); while (!s_axis_tready);
		expected_q.push_back(predict_quotient(act, an, ad, bn, bd));
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Mostly small operands so that results stay in range; now and then a
	// full-width word so every bit moves.
	function automatic logic [31:0] rand_word();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return $urandom_range(0, 1) ? -$urandom_range(0, 60) : $urandom_range(0, 60);
		if (roll < 9)
			return $urandom;
		return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	//--------------------------------------------------------------------------
	// Test tasks.
	//--------------------------------------------------------------------------
	task automatic test_directed();
		send_fractions(ACT_NORM, 32'd6, -32'sd4, 32'd0, 32'd0, 0);
		send_fractions(ACT_NORM, 32'h8000_0000, 32'd1, 32'd1, 32'd1, 1);
		// Negating the most negative numerator does not fit.
		send_fractions(ACT_NORM, 32'h8000_0000, -32'sd1, 32'd1, 32'd1, 0);
		// A denominator of magnitude two to the 31st overflows.
		send_fractions(ACT_NORM, 32'd1, 32'h8000_0000, 32'd1, 32'd1, 0);
		send_fractions(ACT_NORM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd1, 0);
		send_fractions(ACT_NORM, 32'd0, -32'sd7, 32'd1, 32'd1, 2);
		send_fractions(ACT_NORM, 32'd3, 32'd0, 32'd1, 32'd1, 0);
		send_fractions(ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 0);
		send_fractions(ACT_ADD, 32'd1, 32'd2, -32'sd1, 32'd2, 0);
		send_fractions(ACT_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1, 0);
		send_fractions(ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd0, 3);
		send_fractions(ACT_SUB, 32'd1, 32'd3, 32'd1, 32'd2, 0);
		send_fractions(ACT_SUB, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, -32'sd1, 0);
		send_fractions(ACT_MUL, -32'sd2, 32'd3, 32'd9, -32'sd4, 0);
		send_fractions(ACT_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3, 0);
		send_fractions(ACT_DIV, 32'd2, 32'd3, -32'sd4, 32'd9, 0);
		send_fractions(ACT_DIV, 32'd2, 32'd3, 32'd0, 32'd5, 0);
		send_fractions(ACT_CMP, 32'd1, 32'd3, 32'd1, 32'd2, 0);
		send_fractions(ACT_CMP, 32'd2, 32'd4, -32'sd3, -32'sd6, 0);
		send_fractions(ACT_CMP, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd1, 1);
		send_fractions(ACT_CMP, 32'd1, 32'd1, 32'd1, 32'd0, 0);
		send_fractions(ACT_SPLIT, 32'd7, -32'sd2, 32'd0, 32'd0, 0);
		send_fractions(ACT_SPLIT, 32'h8000_0000, 32'd1, 32'd5, 32'd0, 0);
		send_fractions(ACT_SPLIT, 32'd0, 32'd0, 32'd1, 32'd1, 0);
		send_fractions(ACT_NONE, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 0);
	endtask

	task automatic test_random(int count);
		action_t act;
		for (int i = 0; i < count; i++) begin
			act = action_t'($urandom_range(0, 7));
			send_fractions(act, rand_word(), rand_word(), rand_word(), rand_word(),
				pick_gap());
		end
	endtask

	// The receiver holds off longer than the slowest item while the sender
	// keeps offering beats.
	task automatic test_backpressure();
		rx_hold = 15000;
		for (int i = 0; i < 6; i++)
			send_fractions(action_t'($urandom_range(0, 6)), rand_word(), rand_word(),
				rand_word(), rand_word(), 0);
	endtask

	// The sender waits for every outstanding result before going on.
	task automatic test_drain_pause();
		drain_results();
		test_random(20);
	endtask

	//--------------------------------------------------------------------------
	// Output side: random stalls, and a long hold-off when one is requested.
	//--------------------------------------------------------------------------
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (rx_stall > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else if ($urandom_range(0, 9) < 2) begin
			m_axis_tready <= 1'b0;
			rx_stall <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
				: $urandom_range(15, 60);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Each result beat is compared with the oldest prediction.
	always @(posedge clk) begin
		quotient_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				$error("Result beat with no prediction pending: %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				if (m_axis_tdata[31:0] !== want.num) begin
					$error("res_num: expected %h, got %h", want.num, m_axis_tdata[31:0]);
					fail_count++;
				end
				if (m_axis_tdata[62:32] !== want.den) begin
					$error("res_den: expected %h, got %h", want.den, m_axis_tdata[62:32]);
					fail_count++;
				end
				if (m_axis_tdata[94:63] !== want.ipart) begin
					$error("int_part: expected %h, got %h", want.ipart, m_axis_tdata[94:63]);
					fail_count++;
				end
				if (m_axis_tdata[95] !== want.lt) begin
					$error("is_less: expected %b, got %b", want.lt, m_axis_tdata[95]);
					fail_count++;
				end
				if (m_axis_tdata[96] !== want.eq) begin
					$error("is_equal: expected %b, got %b", want.eq, m_axis_tdata[96]);
					fail_count++;
				end
				if (m_axis_tdata[97] !== want.gt) begin
					$error("is_greater: expected %b, got %b", want.gt, m_axis_tdata[97]);
					fail_count++;
				end
				if (m_axis_tdata[99:98] !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, m_axis_tdata[99:98]);
					fail_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(180);
		test_backpressure();
		test_drain_pause();
		test_random(180);
		drain_results();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/rau_pkg.sv
hdl/rau_divider.sv
hdl/rational_arith_unit.sv
verif/rational_arith_unit_tb.sv
